FILE: hw/rtl/thermometer_scratchpad_decode_defines.svh
// Assertion macros shared by the scratchpad decoder queue and back-end modules.
// Each macro expects clk and rst_n in scope.
`ifndef THERMOMETER_SCRATCHPAD_DECODE_DEFINES_SVH
`define THERMOMETER_SCRATCHPAD_DECODE_DEFINES_SVH

// Condition must never hold.
`define TSD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tsd_pkg.sv
package tsd_pkg;

    // Scratchpad byte positions
    localparam logic [3:0] IDX_TEMP_LO       = 4'd0;
    localparam logic [3:0] IDX_TEMP_HI       = 4'd1;
    localparam logic [3:0] IDX_CONFIG        = 4'd4;
    localparam logic [3:0] IDX_COUNT_REMAIN  = 4'd6;
    localparam logic [3:0] IDX_COUNT_PER_DEG = 4'd7;
    localparam logic [3:0] IDX_CRC           = 4'd8;
    localparam logic [3:0] IDX_DONE          = 4'd9;

    localparam logic [7:0]  FAMILY_TYPE_S    = 8'h10;
    localparam logic [7:0]  CPD_FULL         = 8'h10;
    localparam logic [15:0] TYPE_S_INT_MASK  = 16'hFFF0;
    localparam logic [15:0] TYPE_S_BIAS      = 16'd12;

    localparam logic [7:0]  RES_MASK         = 8'h60;
    localparam logic [7:0]  RES_9BIT         = 8'h00;
    localparam logic [7:0]  RES_10BIT        = 8'h20;
    localparam logic [7:0]  RES_11BIT        = 8'h40;

    localparam int QUEUE_DEPTH = 2;

    // One completed frame, handed from the front end to the converter
    typedef struct packed {
        logic [15:0] temp_word;
        logic [7:0]  resolution;
        logic [7:0]  count_remain;
        logic [7:0]  count_per_degree;
        logic [7:0]  family;
        logic        crc_ok;
    } tsd_job_t;

    typedef struct packed {
        logic     push;
        tsd_job_t job;
    } tsd_push_t;

endpackage

FILE: hw/rtl/tsd_front.sv
module tsd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          family_code,
    input  logic                frame_start,
    input  logic                queue_full,
    output tsd_pkg::tsd_push_t  enq
);
    import tsd_pkg::*;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg;
    logic [7:0]  resolution_reg;
    logic [7:0]  count_remain_reg;
    logic [7:0]  count_per_degree_reg;

    logic        accept;
    logic [3:0]  idx_eff;
    logic [7:0]  crc_eff;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // Frame start restarts the counter and CRC for this very byte
    assign idx_eff = frame_start ? IDX_TEMP_LO : idx_reg;
    assign crc_eff = frame_start ? 8'h00 : crc_reg;

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            if (idx_eff < IDX_CRC)
            begin
                idx_next = idx_eff + 4'd1;
                crc_next = crc8_update(crc_eff, data_byte);
            end
            else
            begin
                // Hold at done until the next frame start
                idx_next = IDX_DONE;
                crc_next = crc_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_TEMP_LO;
            crc_reg <= 8'h00;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unique case (idx_eff)
                IDX_TEMP_LO:       temp_word_reg[7:0]   <= data_byte;
                IDX_TEMP_HI:       temp_word_reg[15:8]  <= data_byte;
                IDX_CONFIG:        resolution_reg       <= data_byte;
                IDX_COUNT_REMAIN:  count_remain_reg     <= data_byte;
                IDX_COUNT_PER_DEG: count_per_degree_reg <= data_byte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        enq.push                 = accept && (idx_eff == IDX_CRC);
        enq.job.temp_word        = temp_word_reg;
        enq.job.resolution       = resolution_reg;
        enq.job.count_remain     = count_remain_reg;
        enq.job.count_per_degree = count_per_degree_reg;
        enq.job.family           = family_code;
        enq.job.crc_ok           = (crc_eff == data_byte);
    end

endmodule

FILE: hw/rtl/tsd_queue.sv
`include "thermometer_scratchpad_decode_defines.svh"

module tsd_queue #(
    parameter int Depth = tsd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsd_pkg::tsd_push_t  enq,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tsd_pkg::tsd_job_t   head
);
    import tsd_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    tsd_job_t            entry_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full      = (count_reg == CntW'(Depth));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq.push)
        begin
            entry_reg[wr_ptr_reg] <= enq.job;
        end
    end

    `TSD_ASSERT_NEVER(a_no_push_full, enq.push && full, "push into full queue")
    `TSD_ASSERT_NEVER(a_no_pop_empty, pop && !not_empty, "pop from empty queue")
    `TSD_ASSERT_NEXT(a_cnt_up, enq.push && !pop, count_reg == $past(count_reg) + 1'b1, "bad count")

endmodule

FILE: hw/rtl/tsd_back.sv
`include "thermometer_scratchpad_decode_defines.svh"

module tsd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  tsd_pkg::tsd_job_t  head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temp_sixteenths,
    output logic               crc_valid
);
    import tsd_pkg::*;

    function automatic logic [15:0] convert(input tsd_job_t job);
        logic [15:0] raw;
        logic [7:0]  res;
        raw = job.temp_word;
        res = job.resolution & RES_MASK;
        if (job.family == FAMILY_TYPE_S)
        begin
            raw = {raw[12:0], 3'b000};
            if (job.count_per_degree == CPD_FULL)
            begin
                raw = (raw & TYPE_S_INT_MASK) + TYPE_S_BIAS - {8'h00, job.count_remain};
            end
        end
        else
        begin
            // Clear the bits left undefined by the resolution; 12-bit keeps all
            unique case (res)
                RES_9BIT:  raw = raw & 16'hFFF8;
                RES_10BIT: raw = raw & 16'hFFFC;
                RES_11BIT: raw = raw & 16'hFFFE;
                default: ;
            endcase
        end
        return raw;
    endfunction

    logic        out_valid_reg, out_valid_next;
    logic [15:0] temp_reg;
    logic        crc_valid_reg;

    assign pop = not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            temp_reg      <= head.crc_ok ? convert(head) : 16'h0000;
            crc_valid_reg <= head.crc_ok;
        end
    end

    assign out_valid       = out_valid_reg;
    assign temp_sixteenths = signed'(temp_reg);
    assign crc_valid       = crc_valid_reg;

    `TSD_ASSERT_IMPL(a_bad_crc_zero, out_valid && !crc_valid, temp_reg == '0, "nonzero temp")
    `TSD_ASSERT_NEXT(a_pop_shows, pop, out_valid_reg, "popped job not presented")
    `TSD_ASSERT_NEVER(a_hold_stalled, pop && out_valid && out_stall, "stalled result lost")

endmodule

FILE: hw/rtl/thermometer_scratchpad_decode.sv
// Channel | Handshake             | Payload
// --------+-----------------------+----------------------------------------
// in      | in_valid / in_stall   | data_byte, family_code, frame_start
// out     | out_valid / out_stall | temp_sixteenths, crc_valid
//
// While in_stall is low, one scratchpad byte is taken every cycle and the CRC-8 update is one byte per cycle.
// A job enters the queue with the ninth (CRC) byte; the converter pops it and holds the result in the output register.
// in_stall rises only while the frame queue between front end and converter is full.
// rst_n clears the byte counter, CRC, queue pointers and output valid.
module thermometer_scratchpad_decode #(
    parameter int QueueDepth = tsd_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         family_code,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temp_sixteenths,
    output logic               crc_valid
);
    import tsd_pkg::*;

    tsd_push_t enq;
    tsd_job_t  head;
    logic      queue_full;
    logic      queue_not_empty;
    logic      pop;

    tsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .family_code (family_code),
        .frame_start (frame_start),
        .queue_full  (queue_full),
        .enq         (enq)
    );

    tsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    tsd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .not_empty       (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .temp_sixteenths (temp_sixteenths),
        .crc_valid       (crc_valid)
    );

endmodule
